/* hdl/dtmt_pkg.sv */
`default_nettype none
package dtmt_pkg;

	// Table geometry
	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths
	localparam int ACTION_W      = 3;
	localparam int DATE_W        = 27;
	localparam int MASK_W        = 32;
	localparam int STATUS_W      = 2;
	localparam int ENTRY_COUNT_W = 11;
	localparam int S_TDATA_W     = 64;
	localparam int M_TDATA_W     = 48;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_UPDATE = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

	// Date split: YYYYMMDD -> year, month, day by reciprocal multiplies
	localparam int YEAR_W       = 14;
	localparam int REM_W        = 14;
	localparam int MD_W         = 7;
	localparam int YEAR_MIN     = 1970;
	localparam int YEAR_MAX     = 2100;
	localparam int YEAR_SCALE   = 10000;
	localparam int MONTH_SCALE  = 100;
	localparam int MONTH_MAX    = 12;
	localparam int DIV10K_SHIFT = 41;
	localparam int DIV10K_W     = 28;
	localparam logic [DIV10K_W-1:0] DIV10K_RECIP = 28'd219902326;
	localparam int DIV100_SHIFT = 21;
	localparam int DIV100_W     = 15;
	localparam logic [DIV100_W-1:0] DIV100_RECIP = 15'd20972;

	// Queue between classifier and table engine
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic                bad_date;
		logic [MASK_W-1:0]   mask;
		logic [DATE_W-1:0]   key;
		logic [ACTION_W-1:0] action;
	} qent_t;

	// Result item; status sits in the lowest bits
	typedef struct packed {
		logic [ENTRY_COUNT_W-1:0] entry_count;
		logic                     matches_res;
		logic                     found;
		logic [MASK_W-1:0]        entry_types;
		logic [STATUS_W-1:0]      status;
	} res_t;

	function automatic logic [MD_W-1:0] month_limit(input logic [MD_W-1:0] month);
		logic [MD_W-1:0] lim;
		unique case (month)
			7'd1:    lim = 7'd31;
			7'd2:    lim = 7'd29;
			7'd3:    lim = 7'd31;
			7'd4:    lim = 7'd30;
			7'd5:    lim = 7'd31;
			7'd6:    lim = 7'd30;
			7'd7:    lim = 7'd31;
			7'd8:    lim = 7'd31;
			7'd9:    lim = 7'd30;
			7'd10:   lim = 7'd31;
			7'd11:   lim = 7'd30;
			7'd12:   lim = 7'd31;
			default: lim = 7'd0;
		endcase
		return lim;
	endfunction

endpackage
`default_nettype wire

/* hdl/dtmt_ram.sv */
`default_nettype none
module dtmt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                   wdata,
	input  wire logic                               re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                   rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* hdl/dtmt_front.sv */
`default_nettype none
module dtmt_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [dtmt_pkg::ACTION_W-1:0]     in_action,
	input  wire logic [dtmt_pkg::DATE_W-1:0]       in_key,
	input  wire logic [dtmt_pkg::MASK_W-1:0]       in_mask,
	output logic                                   push,
	output dtmt_pkg::qent_t                        push_data,
	input  wire logic                              q_full
);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_YEAR = 3'd1;
	localparam logic [2:0] F_REM  = 3'd2;
	localparam logic [2:0] F_MON  = 3'd3;
	localparam logic [2:0] F_CHK  = 3'd4;

	localparam int PY_W = dtmt_pkg::DATE_W + dtmt_pkg::DIV10K_W;
	localparam int PM_W = dtmt_pkg::REM_W + dtmt_pkg::DIV100_W;

	logic [2:0]                      fst_q;
	logic [dtmt_pkg::ACTION_W-1:0]   action_q;
	logic [dtmt_pkg::DATE_W-1:0]     key_q;
	logic [dtmt_pkg::MASK_W-1:0]     mask_q;
	logic [dtmt_pkg::YEAR_W-1:0]     year_q;
	logic [dtmt_pkg::REM_W-1:0]      rem_q;
	logic [dtmt_pkg::MD_W-1:0]       mon_q;

	logic [PY_W-1:0]                 prod_year;
	logic [dtmt_pkg::DATE_W-1:0]     year_scaled;
	logic [PM_W-1:0]                 prod_mon;
	logic [dtmt_pkg::MD_W-1:0]       day;
	logic                            bad_date;

	assign in_ready = (fst_q == F_IDLE);

	// year = date / 10000, exact for every 27-bit date
	assign prod_year   = PY_W'(key_q) * PY_W'(dtmt_pkg::DIV10K_RECIP);
	assign year_scaled = dtmt_pkg::DATE_W'(
		(dtmt_pkg::DATE_W + 1)'(year_q) * (dtmt_pkg::DATE_W + 1)'(dtmt_pkg::YEAR_SCALE));
	// month = rem / 100
	assign prod_mon    = PM_W'(rem_q) * PM_W'(dtmt_pkg::DIV100_RECIP);
	assign day         = dtmt_pkg::MD_W'(rem_q -
		dtmt_pkg::REM_W'(dtmt_pkg::REM_W'(mon_q) * dtmt_pkg::REM_W'(dtmt_pkg::MONTH_SCALE)));

	assign bad_date = (year_q < dtmt_pkg::YEAR_W'(dtmt_pkg::YEAR_MIN)) ||
			(year_q > dtmt_pkg::YEAR_W'(dtmt_pkg::YEAR_MAX)) ||
			(mon_q == '0) ||
			(mon_q > dtmt_pkg::MD_W'(dtmt_pkg::MONTH_MAX)) ||
			(day == '0) ||
			(day > dtmt_pkg::month_limit(mon_q));

	assign push = (fst_q == F_CHK) && !q_full;

	always_comb begin
		push_data.bad_date = bad_date;
		push_data.mask     = mask_q;
		push_data.key      = key_q;
		push_data.action   = action_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_IDLE;
		end else begin
			unique case (fst_q)
				F_IDLE: if (in_valid) begin
					fst_q <= F_YEAR;
				end
				F_YEAR: fst_q <= F_REM;
				F_REM:  fst_q <= F_MON;
				F_MON:  fst_q <= F_CHK;
				F_CHK:  if (!q_full) begin
					fst_q <= F_IDLE;
				end
				default: fst_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_q <= in_action;
			key_q    <= in_key;
			mask_q   <= in_mask;
		end
		if (fst_q == F_YEAR) begin
			year_q <= prod_year[dtmt_pkg::DIV10K_SHIFT +: dtmt_pkg::YEAR_W];
		end
		if (fst_q == F_REM) begin
			rem_q <= dtmt_pkg::REM_W'(key_q - year_scaled);
		end
		if (fst_q == F_MON) begin
			mon_q <= prod_mon[dtmt_pkg::DIV100_SHIFT +: dtmt_pkg::MD_W];
		end
	end

endmodule
`default_nettype wire

/* hdl/dtmt_queue.sv */
`default_nettype none
module dtmt_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire dtmt_pkg::qent_t  push_data,
	output logic                  full,
	input  wire logic             pop,
	output dtmt_pkg::qent_t       pop_data,
	output logic                  empty
);

	dtmt_pkg::qent_t               ent_q [dtmt_pkg::QUEUE_DEPTH];
	logic [dtmt_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [dtmt_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [dtmt_pkg::QCNT_W-1:0]   fill_q;

	localparam logic [dtmt_pkg::QPTR_W-1:0] PTR_LAST =
		dtmt_pkg::QPTR_W'(dtmt_pkg::QUEUE_DEPTH - 1);

	assign full     = (fill_q == dtmt_pkg::QCNT_W'(dtmt_pkg::QUEUE_DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : dtmt_pkg::QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : dtmt_pkg::QPTR_W'(rd_ptr_q + 1'b1);
			end
			priority if ((push && !full) && !(pop && !empty)) begin
				fill_q <= dtmt_pkg::QCNT_W'(fill_q + 1'b1);
			end else if (!(push && !full) && (pop && !empty)) begin
				fill_q <= dtmt_pkg::QCNT_W'(fill_q - 1'b1);
			end else begin
				fill_q <= fill_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

/* hdl/dtmt_back.sv */
`default_nettype none
module dtmt_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  wire dtmt_pkg::qent_t q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output dtmt_pkg::res_t     out_res
);

	localparam logic [2:0] B_IDLE    = 3'd0;
	localparam logic [2:0] B_SEARCH  = 3'd1;
	localparam logic [2:0] B_ACT     = 3'd2;
	localparam logic [2:0] B_DROP_RD = 3'd3;
	localparam logic [2:0] B_DROP_WR = 3'd4;

	localparam int AW = dtmt_pkg::ADDR_W;
	localparam int CW = dtmt_pkg::CNT_W;

	logic [2:0]                    bst_q, bst_d;
	logic [CW-1:0]                 cnt_q, cnt_d;
	logic [CW-1:0]                 iss_q, iss_d;
	logic                          pend_q, pend_d;
	logic [AW-1:0]                 pend_idx_q, pend_idx_d;
	logic                          hit_q, hit_d;
	logic [AW-1:0]                 slot_q, slot_d;
	logic [dtmt_pkg::MASK_W-1:0]   smask_q, smask_d;
	dtmt_pkg::qent_t               cmd_q, cmd_d;
	logic                          out_valid_q;
	dtmt_pkg::res_t                res_q, res_d;
	logic                          ld_res;

	logic                          ram_we, ram_re;
	logic [AW-1:0]                 ram_waddr, ram_raddr;
	logic [dtmt_pkg::DATE_W-1:0]   wdate, date_rd;
	logic [dtmt_pkg::MASK_W-1:0]   wmask, mask_rd, new_mask;
	logic                          hit_now;

	dtmt_ram #(.WIDTH(dtmt_pkg::DATE_W), .DEPTH(dtmt_pkg::CAPACITY)) u_dates (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wdate),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (date_rd)
	);

	dtmt_ram #(.WIDTH(dtmt_pkg::MASK_W), .DEPTH(dtmt_pkg::CAPACITY)) u_masks (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wmask),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (mask_rd)
	);

	assign hit_now   = pend_q && (date_rd == cmd_q.key);
	assign new_mask  = smask_q & ~cmd_q.mask;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_comb begin
		bst_d      = bst_q;
		cnt_d      = cnt_q;
		iss_d      = iss_q;
		pend_d     = 1'b0;
		pend_idx_d = pend_idx_q;
		hit_d      = hit_q;
		slot_d     = slot_q;
		smask_d    = smask_q;
		cmd_d      = cmd_q;
		q_pop      = 1'b0;
		ld_res     = 1'b0;
		res_d      = '0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = '0;
		ram_raddr  = '0;
		wdate      = cmd_q.key;
		wmask      = cmd_q.mask;

		unique case (bst_q)
			B_IDLE: begin
				if (!q_empty && !out_valid_q) begin
					q_pop = 1'b1;
					cmd_d = q_data;
					priority if (((q_data.action == dtmt_pkg::ACT_ADD) ||
							(q_data.action == dtmt_pkg::ACT_UPDATE)) && q_data.bad_date) begin
						ld_res       = 1'b1;
						res_d.status = dtmt_pkg::ST_BAD_DATE;
					end else if (q_data.action == dtmt_pkg::ACT_CLEAR) begin
						cnt_d  = '0;
						ld_res = 1'b1;
					end else if (q_data.action > dtmt_pkg::ACT_LOOKUP) begin
						ld_res = 1'b1;
					end else begin
						bst_d = B_SEARCH;
						iss_d = '0;
					end
				end
			end
			B_SEARCH: begin
				// compare the entry read last cycle while the next read goes out
				priority if (hit_now) begin
					hit_d   = 1'b1;
					slot_d  = pend_idx_q;
					smask_d = mask_rd;
					bst_d   = B_ACT;
				end else if (iss_q < cnt_q) begin
					ram_re     = 1'b1;
					ram_raddr  = iss_q[AW-1:0];
					pend_d     = 1'b1;
					pend_idx_d = iss_q[AW-1:0];
					iss_d      = CW'(iss_q + 1'b1);
				end else begin
					hit_d = 1'b0;
					bst_d = B_ACT;
				end
			end
			B_ACT: begin
				bst_d  = B_IDLE;
				ld_res = 1'b1;
				unique case (cmd_q.action)
					dtmt_pkg::ACT_ADD, dtmt_pkg::ACT_UPDATE: begin
						priority if (hit_q) begin
							ram_we    = 1'b1;
							ram_waddr = slot_q;
							wmask     = (cmd_q.action == dtmt_pkg::ACT_ADD) ?
									(smask_q | cmd_q.mask) : cmd_q.mask;
						end else if (cnt_q >= CW'(dtmt_pkg::CAPACITY)) begin
							res_d.status = dtmt_pkg::ST_FULL;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = cnt_q[AW-1:0];
							cnt_d     = CW'(cnt_q + 1'b1);
						end
					end
					dtmt_pkg::ACT_REMOVE: begin
						priority if (!hit_q) begin
							res_d.status = dtmt_pkg::ST_NOTFOUND;
						end else if (new_mask != '0) begin
							ram_we    = 1'b1;
							ram_waddr = slot_q;
							wmask     = new_mask;
						end else begin
							ld_res = 1'b0;
							bst_d  = B_DROP_RD;
						end
					end
					dtmt_pkg::ACT_DELETE: begin
						if (!hit_q) begin
							res_d.status = dtmt_pkg::ST_NOTFOUND;
						end else begin
							ld_res = 1'b0;
							bst_d  = B_DROP_RD;
						end
					end
					dtmt_pkg::ACT_LOOKUP: begin
						res_d.found       = hit_q;
						res_d.entry_types = hit_q ? smask_q : '0;
						res_d.matches_res = hit_q && ((smask_q & cmd_q.mask) != '0);
					end
					default: begin
					end
				endcase
			end
			B_DROP_RD: begin
				// fetch the last valid entry to fill the freed slot
				ram_re    = 1'b1;
				ram_raddr = AW'(cnt_q - 1'b1);
				bst_d     = B_DROP_WR;
			end
			B_DROP_WR: begin
				ram_we    = 1'b1;
				ram_waddr = slot_q;
				wdate     = date_rd;
				wmask     = mask_rd;
				cnt_d     = CW'(cnt_q - 1'b1);
				ld_res    = 1'b1;
				bst_d     = B_IDLE;
			end
			default: bst_d = B_IDLE;
		endcase

		res_d.entry_count = dtmt_pkg::ENTRY_COUNT_W'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q       <= B_IDLE;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			bst_q  <= bst_d;
			cnt_q  <= cnt_d;
			pend_q <= pend_d;
			priority if (ld_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end else begin
				out_valid_q <= out_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		iss_q      <= iss_d;
		pend_idx_q <= pend_idx_d;
		hit_q      <= hit_d;
		slot_q     <= slot_d;
		smask_q    <= smask_d;
		cmd_q      <= cmd_d;
		if (ld_res) begin
			res_q <= res_d;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(dtmt_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_pend_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(bst_q == B_SEARCH) && pend_q |-> (CW'(pend_idx_q) < cnt_q))
		else $error("pending compare outside valid entries");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(bst_q == B_IDLE) |-> !ram_we)
		else $error("table written while idle");

	a_drop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(bst_q == B_DROP_WR) |=> (cnt_q == CW'($past(cnt_q) - 1'b1)))
		else $error("entry removal did not shrink the count");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		ld_res |-> !out_valid_q)
		else $error("result loaded over one still waiting");

endmodule
`default_nettype wire

/* hdl/dated_type_mask_table.sv */
`default_nettype none
// Channel  Dir  Bits  Contents (lowest bit first)
// s_*      in   64    action[2:0], date_key[29:3], type_mask[61:30], zero[63:62]
// m_*      out  48    status[1:0], entry_types[33:2], found[34], matches_res[35],
//                     entry_count[46:36], zero[47]
//
// Timing: the classifier splits the date in year, remainder, month and check
// states and takes a new item only once the last is pushed; the table engine
// scans the stored entries at one compare per cycle through the memory read
// port; a drop adds a read and a write (last entry moved into the freed slot).
// Reset: arst_n clears control state and the entry count; the memories are not
// cleared and need no clearing pass.
// Stalls: a two-entry queue decouples classifier and engine; a held result on
// m_* blocks only the engine, the classifier keeps taking items until the
// queue fills.
module dated_type_mask_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// action, date_key, type_mask, zero pad
	input  wire logic [dtmt_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// status, entry_types, found, matches_res, entry_count, zero pad
	output logic      [dtmt_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int KEY_LO  = dtmt_pkg::ACTION_W;
	localparam int MASK_LO = dtmt_pkg::ACTION_W + dtmt_pkg::DATE_W;
	localparam int RES_W   = $bits(dtmt_pkg::res_t);

	logic              push, q_full, q_pop, q_empty;
	dtmt_pkg::qent_t   push_data, q_data;
	dtmt_pkg::res_t    res;

	// Classify: take the item and check its date
	dtmt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (s_tdata[dtmt_pkg::ACTION_W-1:0]),
		.in_key    (s_tdata[KEY_LO +: dtmt_pkg::DATE_W]),
		.in_mask   (s_tdata[MASK_LO +: dtmt_pkg::MASK_W]),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// Hold classified items until the engine is free
	dtmt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	// Search and modify the table, drive the result register
	dtmt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {{(dtmt_pkg::M_TDATA_W - RES_W){1'b0}}, res};

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;

	import dtmt_pkg::*;

	// Unused action codes: the block must answer them with status ok and no change
	localparam logic [ACTION_W-1:0] ACT_SPARE6 = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE7 = 3'd7;

	localparam int DATE_KEY_MAX     = 99999999;
	localparam int POOL_SIZE        = 20;
	localparam int RANDOM_PER_PHASE = 190;
	localparam int HOLD_AT          = 60;    // results seen before the long output hold
	localparam int HOLD_CYCLES      = 400;
	localparam int WATCHDOG_LIMIT   = 20000; // full-table scan plus hold, several times over
	localparam int DRAIN_CYCLES     = 64;
	localparam int MONTH_DAYS [12]  = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [DATE_W-1:0]   date;
		logic [MASK_W-1:0]   mask;
	} request_t;

	// One row of the directed table; typed rows carry their answer, others use the predictor
	typedef struct packed {
		request_t rq;
		bit       typed;
		res_t     want;
	} dir_row_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// Shadow copy of the table, advanced once per accepted request
	logic [DATE_W-1:0] shadow_dates [0:CAPACITY-1];
	logic [MASK_W-1:0] shadow_masks [0:CAPACITY-1];
	int                shadow_count;

	res_t              pending_results [$];
	logic [DATE_W-1:0] date_pool [0:POOL_SIZE-1];

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int error_count  = 0;
	int results_seen = 0;
	int hold_left    = 0;
	int idle_cycles  = 0;
	int n_requests   = 0;
	int n_full       = 0;
	int n_bad_date   = 0;
	int peak_count   = 0;
	res_t got_res, want_res;

	dated_type_mask_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string field, input logic [31:0] seen,
			input logic [31:0] wanted);
		$display("%0t: result %0d %s: got %h, expected %h", $time, results_seen, field,
			seen, wanted);
		error_count++;
	endtask

	function automatic bit date_is_legal(input logic [DATE_W-1:0] d);
		int year, month, day;
		year  = d / YEAR_SCALE;
		month = (d / MONTH_SCALE) % MONTH_SCALE;
		day   = d % MONTH_SCALE;
		if (year < YEAR_MIN || year > YEAR_MAX || month < 1 || month > MONTH_MAX)
			return 1'b0;
		return day >= 1 && day <= MONTH_DAYS[month - 1];
	endfunction

	// Slot holding the date, or -1 when the date is not stored
	function automatic int locate_date(input logic [DATE_W-1:0] d);
		for (int i = 0; i < shadow_count; i++)
			if (shadow_dates[i] == d) return i;
		return -1;
	endfunction

	// Apply one request to the shadow table and return the answer it must produce
	function automatic res_t apply_request(input request_t rq);
		res_t r;
		int   slot;
		r = '0;
		case (rq.action)
			ACT_ADD, ACT_UPDATE: begin
				if (!date_is_legal(rq.date)) begin
					r.status = ST_BAD_DATE;
				end else begin
					slot = locate_date(rq.date);
					if (slot >= 0) begin
						if (rq.action == ACT_ADD) shadow_masks[slot] |= rq.mask;
						else shadow_masks[slot] = rq.mask;
					end else if (shadow_count >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						shadow_dates[shadow_count] = rq.date;
						shadow_masks[shadow_count] = rq.mask;
						shadow_count++;
					end
				end
			end
			ACT_REMOVE, ACT_DELETE: begin
				slot = locate_date(rq.date);
				if (slot < 0) begin
					r.status = ST_NOTFOUND;
				end else begin
					if (rq.action == ACT_REMOVE) shadow_masks[slot] &= ~rq.mask;
					// drop the entry: move the last one into the freed slot
					if (rq.action == ACT_DELETE || shadow_masks[slot] == '0) begin
						shadow_count--;
						shadow_dates[slot] = shadow_dates[shadow_count];
						shadow_masks[slot] = shadow_masks[shadow_count];
					end
				end
			end
			ACT_CLEAR: shadow_count = 0;
			ACT_LOOKUP: begin
				slot = locate_date(rq.date);
				if (slot >= 0) begin
					r.found       = 1'b1;
					r.entry_types = shadow_masks[slot];
					r.matches_res = (shadow_masks[slot] & rq.mask) != '0;
				end
			end
			default: ;
		endcase
		r.entry_count = shadow_count[ENTRY_COUNT_W-1:0];
		return r;
	endfunction

	function automatic res_t outcome(input logic [STATUS_W-1:0] st, input logic [MASK_W-1:0] types,
			input logic fnd, input logic hit, input int count);
		res_t r;
		r.status      = st;
		r.entry_types = types;
		r.found       = fnd;
		r.matches_res = hit;
		r.entry_count = count[ENTRY_COUNT_W-1:0];
		return r;
	endfunction

	function automatic dir_row_t row(input logic [ACTION_W-1:0] act, input logic [DATE_W-1:0] d,
			input logic [MASK_W-1:0] m, input bit typed, input res_t want);
		dir_row_t r;
		r.rq.action = act;
		r.rq.date   = d;
		r.rq.mask   = m;
		r.typed     = typed;
		r.want      = want;
		return r;
	endfunction

	function automatic logic [DATE_W-1:0] legal_date();
		int y, m;
		y = $urandom_range(YEAR_MAX, YEAR_MIN);
		m = $urandom_range(MONTH_MAX, 1);
		return y * YEAR_SCALE + m * MONTH_SCALE + $urandom_range(MONTH_DAYS[m - 1], 1);
	endfunction

	// Mostly requests on a small set of dates, so that hits, merges and drops are common;
	// the rest are fresh dates, near-miss dates and raw keys
	function automatic request_t random_request();
		request_t rq;
		int       pick;
		pick = $urandom_range(99);
		if (pick < 26)      rq.action = ACT_ADD;
		else if (pick < 40) rq.action = ACT_UPDATE;
		else if (pick < 55) rq.action = ACT_REMOVE;
		else if (pick < 68) rq.action = ACT_DELETE;
		else if (pick < 71) rq.action = ACT_CLEAR;
		else if (pick < 95) rq.action = ACT_LOOKUP;
		else rq.action = ($urandom_range(1) == 0) ? ACT_SPARE6 : ACT_SPARE7;
		pick = $urandom_range(99);
		if (pick < 80)      rq.date = date_pool[$urandom_range(POOL_SIZE - 1)];
		else if (pick < 88) rq.date = legal_date();
		else if (pick < 94) rq.date = $urandom_range(2110, 1960) * YEAR_SCALE
			+ $urandom_range(13, 0) * MONTH_SCALE + $urandom_range(32, 0);
		else rq.date = $urandom_range(DATE_KEY_MAX);
		case ($urandom_range(9))
			0:       rq.mask = '0;
			1:       rq.mask = '1;
			2, 3, 4: rq.mask = 32'h1 << $urandom_range(MASK_W - 1);
			default: rq.mask = $urandom;
		endcase
		return rq;
	endfunction

	// Offer one request, hold it until taken, then record what it must answer
	task automatic send_request(input request_t rq, input bit typed, input res_t fixed);
		res_t want;
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, rq.mask, rq.date, rq.action};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		want = apply_request(rq);
		if (typed) want = fixed;
		pending_results.push_back(want);
		n_requests++;
		if (want.status == ST_FULL) n_full++;
		if (want.status == ST_BAD_DATE) n_bad_date++;
		if (shadow_count > peak_count) peak_count = shadow_count;
	endtask

	// Result side: check each taken item against the oldest expectation, then pick
	// the next tready; one long hold lets the block back up into its input
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res = res_t'(m_tdata[$bits(res_t)-1:0]);
			if (pending_results.size() == 0) begin
				report_mismatch("arrived with nothing pending", got_res[31:0], '0);
			end else begin
				want_res = pending_results.pop_front();
				if (got_res.status != want_res.status)
					report_mismatch("status", 32'(got_res.status), 32'(want_res.status));
				if (got_res.entry_types != want_res.entry_types)
					report_mismatch("entry_types", got_res.entry_types, want_res.entry_types);
				if (got_res.found != want_res.found)
					report_mismatch("found", 32'(got_res.found), 32'(want_res.found));
				if (got_res.matches_res != want_res.matches_res)
					report_mismatch("matches_res", 32'(got_res.matches_res),
						32'(want_res.matches_res));
				if (got_res.entry_count != want_res.entry_count)
					report_mismatch("entry_count", 32'(got_res.entry_count),
						32'(want_res.entry_count));
			end
			results_seen++;
			if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// Watchdog: end the run when neither side moves an item for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("** dated_type_mask_table: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		dir_row_t dir_rows [$];
		shadow_count = 0;
		date_pool[0] = 19700101;
		date_pool[1] = 21001231;
		for (int i = 2; i < POOL_SIZE; i++) date_pool[i] = legal_date();

		// Directed table: empty-table misses, date limits, merge, replace, drops, spare codes
		dir_rows.push_back(row(ACT_LOOKUP, 20240101, 32'h0, 1, outcome(ST_OK, 0, 0, 0, 0)));
		dir_rows.push_back(row(ACT_DELETE, 20240101, 32'h0, 1, outcome(ST_NOTFOUND, 0, 0, 0, 0)));
		dir_rows.push_back(row(ACT_REMOVE, 20240101, '1, 1, outcome(ST_NOTFOUND, 0, 0, 0, 0)));
		dir_rows.push_back(row(ACT_ADD, 19700101, '1, 1, outcome(ST_OK, 0, 0, 0, 1)));
		dir_rows.push_back(row(ACT_ADD, 21001231, 32'h0, 1, outcome(ST_OK, 0, 0, 0, 2)));
		dir_rows.push_back(row(ACT_UPDATE, 20000229, 32'h8000_0001, 1,
			outcome(ST_OK, 0, 0, 0, 3)));
		dir_rows.push_back(row(ACT_ADD, 19691231, '1, 1, outcome(ST_BAD_DATE, 0, 0, 0, 3)));
		dir_rows.push_back(row(ACT_ADD, 21010101, '1, 1, outcome(ST_BAD_DATE, 0, 0, 0, 3)));
		dir_rows.push_back(row(ACT_UPDATE, 20240230, 32'h1, 1,
			outcome(ST_BAD_DATE, 0, 0, 0, 3)));
		dir_rows.push_back(row(ACT_ADD, 20240431, 32'h1, 1, outcome(ST_BAD_DATE, 0, 0, 0, 3)));
		dir_rows.push_back(row(ACT_ADD, 20241301, 32'h1, 1, outcome(ST_BAD_DATE, 0, 0, 0, 3)));
		dir_rows.push_back(row(ACT_ADD, 20240001, 32'h1, 1, outcome(ST_BAD_DATE, 0, 0, 0, 3)));
		dir_rows.push_back(row(ACT_UPDATE, 20240100, 32'h1, 1,
			outcome(ST_BAD_DATE, 0, 0, 0, 3)));
		dir_rows.push_back(row(ACT_ADD, DATE_KEY_MAX, '1, 1, outcome(ST_BAD_DATE, 0, 0, 0, 3)));
		dir_rows.push_back(row(ACT_ADD, 0, 32'h0, 1, outcome(ST_BAD_DATE, 0, 0, 0, 3)));
		dir_rows.push_back(row(ACT_LOOKUP, 19700101, 32'h1, 1, outcome(ST_OK, '1, 1, 1, 3)));
		dir_rows.push_back(row(ACT_LOOKUP, 21001231, '1, 1, outcome(ST_OK, 0, 1, 0, 3)));
		dir_rows.push_back(row(ACT_ADD, 21001231, 32'h0000_00F0, 0, '0));
		dir_rows.push_back(row(ACT_UPDATE, 19700101, 32'h0000_0005, 0, '0));
		// clearing every set bit drops the entry
		dir_rows.push_back(row(ACT_REMOVE, 21001231, 32'h0000_00F0, 1,
			outcome(ST_OK, 0, 0, 0, 2)));
		dir_rows.push_back(row(ACT_UPDATE, 20000229, 32'h0, 0, '0));
		// an entry whose mask is already zero is dropped even by an empty remove
		dir_rows.push_back(row(ACT_REMOVE, 20000229, 32'h0, 1, outcome(ST_OK, 0, 0, 0, 1)));
		dir_rows.push_back(row(ACT_SPARE7, 19700101, '1, 1, outcome(ST_OK, 0, 0, 0, 1)));
		dir_rows.push_back(row(ACT_SPARE6, 19700101, 32'h1, 0, '0));
		dir_rows.push_back(row(ACT_CLEAR, 0, 32'h0, 1, outcome(ST_OK, 0, 0, 0, 0)));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle_pct = 25;
		rcv_idle_pct = 52;
		foreach (dir_rows[i]) send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

		// Random traffic under three stall mixes: sender-light, receiver-light, none
		for (int p = 0; p < 3; p++) begin
			if (p == 1) begin
				snd_idle_pct = 52;
				rcv_idle_pct = 25;
			end else if (p == 2) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			repeat (RANDOM_PER_PHASE) send_request(random_request(), 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		// Drain: wait for every expected answer, then a little longer for strays
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests (%0d answers checked) under three stall mixes and a %0d-cycle",
			n_requests, results_seen, HOLD_CYCLES);
		$display("output hold; table peaked at %0d entries, %0d full and %0d bad-date answers",
			peak_count, n_full, n_bad_date);
		if (error_count == 0) begin
			$display("** dated_type_mask_table: PASSED **");
		end else begin
			$display("%0d mismatches", error_count);
			$display("** dated_type_mask_table: FAILED **");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
hdl/dtmt_pkg.sv
hdl/dtmt_ram.sv
hdl/dtmt_front.sv
hdl/dtmt_queue.sv
hdl/dtmt_back.sv
hdl/dated_type_mask_table.sv
tb/testbench.sv
